// ===== rtl/tpspwm_pkg.sv =====
// Shared types, constants and the sine table builder for the three-phase PWM compare block.
package tpspwm_pkg;

   // Sine table geometry and sample format
   localparam int SINE_TABLE_BITS = 10;
   localparam int SINE_FRAC_BITS  = 16;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int QUARTER_SIZE    = 1 << QUARTER_BITS;
   localparam int ANGLE_DROP      = 32 - SINE_TABLE_BITS;

   // Datapath widths
   localparam int COUNT_W  = 16;
   localparam int PERIOD_W = 16;
   localparam int MOD_W    = 17;
   localparam int STEP_W   = 32;
   localparam int SINE_W   = 31;                      // Q1.30, 0 .. 2^30
   localparam int ENTRY_W  = SINE_FRAC_BITS + 1;      // 0 .. 2^F
   localparam int MP_W     = PERIOD_W + MOD_W;
   localparam int PROD_W   = MP_W + ENTRY_W;
   localparam int SCALE_SH = 16 + SINE_FRAC_BITS;
   localparam int SUB_W    = PROD_W + 1 - SCALE_SH;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Configuration register indexes
   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type REG_PERIOD     = 3'd0;
   localparam csr_addr_type REG_MOD_INDEX  = 3'd1;
   localparam csr_addr_type REG_PHASE_STEP = 3'd2;
   localparam csr_addr_type REG_WRAP_LIMIT = 3'd3;
   localparam csr_addr_type REG_START_A    = 3'd4;
   localparam csr_addr_type REG_START_B    = 3'd5;
   localparam csr_addr_type REG_START_C    = 3'd6;

   localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd5000;
   localparam logic [MOD_W-1:0]    MOD_INDEX_RST  = 17'd65536;
   localparam logic [STEP_W-1:0]   PHASE_STEP_RST = 32'd14316558;
   localparam logic [COUNT_W-1:0]  WRAP_LIMIT_RST = 16'd299;
   localparam logic [COUNT_W-1:0]  START_A_RST    = 16'd0;
   localparam logic [COUNT_W-1:0]  START_B_RST    = 16'd100;
   localparam logic [COUNT_W-1:0]  START_C_RST    = 16'd200;

   typedef enum logic [1:0] {
      PHASE_A,
      PHASE_B,
      PHASE_C
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_INDEX,
      ST_LOOKUP,
      ST_SCALE,
      ST_CLAMP,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic      load_angle;
      logic      load_index;
      logic      load_entry;
      logic      load_product;
      logic      store_compare;
      logic      load_output;
      phase_type phase;
   } dp_cmd_type;

   // sin(k * (pi/2) / QUARTER_SIZE) in Q1.30, quarter-wave Taylor series.
   // Evaluated at elaboration only.
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] prod;
      longint      sum;
      int          n;
      begin
         x    = (64'(k) * HALF_PI_Q30 + 64'(QUARTER_SIZE / 2)) >> QUARTER_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (n = 1; n <= 8; n++) begin
            prod = (term * x2) >> 30;
            case (n)
               1:       term = prod / 6;
               2:       term = prod / 20;
               3:       term = prod / 42;
               4:       term = prod / 72;
               5:       term = prod / 110;
               6:       term = prod / 156;
               7:       term = prod / 210;
               default: term = prod / 272;
            endcase
            if ((n % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
         end
         return SINE_W'(sum);
      end
   endfunction

endpackage

// ===== rtl/tpspwm_ctrl.sv =====
// Sequencer for the three-phase compare computation and the result handshake.
module tpspwm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_tick,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   csr_ready,
   output tpspwm_pkg::dp_cmd_type cmd
);

   tpspwm_pkg::state_type state_ff, state_in;
   tpspwm_pkg::phase_type phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpspwm_pkg::ST_IDLE;
         phase_ff     <= tpspwm_pkg::PHASE_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         tpspwm_pkg::ST_IDLE: begin
            // a word with tick low is taken and dropped
            if (req_valid && req_tick) begin
               state_in = tpspwm_pkg::ST_ANGLE;
               phase_in = tpspwm_pkg::PHASE_A;
            end
         end
         tpspwm_pkg::ST_ANGLE:  state_in = tpspwm_pkg::ST_INDEX;
         tpspwm_pkg::ST_INDEX:  state_in = tpspwm_pkg::ST_LOOKUP;
         tpspwm_pkg::ST_LOOKUP: state_in = tpspwm_pkg::ST_SCALE;
         tpspwm_pkg::ST_SCALE:  state_in = tpspwm_pkg::ST_CLAMP;
         tpspwm_pkg::ST_CLAMP: begin
            case (phase_ff)
               tpspwm_pkg::PHASE_A: begin
                  phase_in = tpspwm_pkg::PHASE_B;
                  state_in = tpspwm_pkg::ST_ANGLE;
               end
               tpspwm_pkg::PHASE_B: begin
                  phase_in = tpspwm_pkg::PHASE_C;
                  state_in = tpspwm_pkg::ST_ANGLE;
               end
               default: begin
                  state_in = tpspwm_pkg::ST_DELIVER;
               end
            endcase
         end
         tpspwm_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = tpspwm_pkg::ST_IDLE;
            end
         end
         default: state_in = tpspwm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.phase = phase_ff;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         tpspwm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
         end
         tpspwm_pkg::ST_ANGLE:   cmd.load_angle    = 1'b1;
         tpspwm_pkg::ST_INDEX:   cmd.load_index    = 1'b1;
         tpspwm_pkg::ST_LOOKUP:  cmd.load_entry    = 1'b1;
         tpspwm_pkg::ST_SCALE:   cmd.load_product  = 1'b1;
         tpspwm_pkg::ST_CLAMP:   cmd.store_compare = 1'b1;
         tpspwm_pkg::ST_DELIVER: cmd.load_output   = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
      rsp_valid_in = cmd.load_output || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_last_phase_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpspwm_pkg::ST_CLAMP && phase_ff == tpspwm_pkg::PHASE_C)
      |=> state_ff == tpspwm_pkg::ST_DELIVER)
      else $error("last phase did not move to delivery");

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == tpspwm_pkg::ST_DELIVER)
      else $error("result valid raised outside delivery");

   a_tick_starts_phase_a: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_tick)
      |=> (state_ff == tpspwm_pkg::ST_ANGLE && phase_ff == tpspwm_pkg::PHASE_A))
      else $error("accepted tick did not start at phase A");
`endif

endmodule

// ===== rtl/tpspwm_datapath.sv =====
// Config registers, phase counters and the shared angle/sine/scale datapath.
module tpspwm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tpspwm_pkg::dp_cmd_type               cmd,
   input  logic                                 csr_write,
   input  tpspwm_pkg::csr_addr_type             csr_index,
   input  logic [31:0]                          csr_wdata,
   output logic [tpspwm_pkg::PERIOD_W-1:0]      rsp_compare_a,
   output logic [tpspwm_pkg::PERIOD_W-1:0]      rsp_compare_b,
   output logic [tpspwm_pkg::PERIOD_W-1:0]      rsp_compare_c
);

   localparam int CW  = tpspwm_pkg::COUNT_W;
   localparam int PW  = tpspwm_pkg::PERIOD_W;
   localparam int TB  = tpspwm_pkg::SINE_TABLE_BITS;
   localparam int QB  = tpspwm_pkg::QUARTER_BITS;
   localparam int SW  = tpspwm_pkg::SINE_W;
   localparam int EW  = tpspwm_pkg::ENTRY_W;
   localparam int FB  = tpspwm_pkg::SINE_FRAC_BITS;
   localparam int DR  = tpspwm_pkg::ANGLE_DROP;
   localparam int NUM_W = 32 + FB;

   // configuration
   logic [PW-1:0]                    period_ff;
   logic [tpspwm_pkg::MOD_W-1:0]     mod_index_ff;
   logic [tpspwm_pkg::STEP_W-1:0]    phase_step_ff;
   logic [CW-1:0]                    wrap_limit_ff;
   logic [CW-1:0]                    count_a_ff, count_b_ff, count_c_ff;
   logic [CW-1:0]                    count_a_in, count_b_in, count_c_in;

   // working registers
   logic [31:0]                      angle_ff;
   logic [tpspwm_pkg::MP_W-1:0]      mp_ff;
   logic [QB:0]                      k_ff;
   logic                             neg_ff;
   logic [EW-1:0]                    entry_ff;
   logic [tpspwm_pkg::PROD_W-1:0]    prod_ff;
   logic [PW-1:0]                    comp_a_ff, comp_b_ff, comp_c_ff;
   logic [PW-1:0]                    out_a_ff, out_b_ff, out_c_ff;

   logic [CW-1:0]                    count_sel;
   logic [47:0]                      angle_full;
   logic [tpspwm_pkg::MP_W-1:0]      mp_in;
   logic [TB+1:0]                    idx_rnd;
   logic [TB-1:0]                    idx;
   logic [QB:0]                      k_in;
   logic [SW-1:0]                    quarter_rom [0:tpspwm_pkg::QUARTER_SIZE];
   logic [SW-1:0]                    sine_q30;
   logic [31:0]                      num;
   logic [NUM_W-1:0]                 entry_full;
   logic [tpspwm_pkg::PROD_W:0]      prod_rnd;
   logic [tpspwm_pkg::SUB_W-1:0]     sub;
   logic [PW-1:0]                    compare;

   // quarter-wave sine table, built at elaboration
   for (genvar g = 0; g <= tpspwm_pkg::QUARTER_SIZE; g++) begin : g_rom
      localparam logic [SW-1:0] SINE_VAL = tpspwm_pkg::quarter_sine(g);
      assign quarter_rom[g] = SINE_VAL;
   end

   always_comb begin
      case (cmd.phase)
         tpspwm_pkg::PHASE_A: count_sel = count_a_ff;
         tpspwm_pkg::PHASE_B: count_sel = count_b_ff;
         tpspwm_pkg::PHASE_C: count_sel = count_c_ff;
         default:             count_sel = count_a_ff;
      endcase
   end

   assign angle_full = {32'd0, count_sel} * {16'd0, phase_step_ff};
   assign mp_in      = {{(tpspwm_pkg::MOD_W){1'b0}}, period_ff}
                     * {{(PW){1'b0}}, mod_index_ff};

   // round the angle to the table index, fold onto the quarter wave
   assign idx_rnd = {1'b0, angle_ff[31:DR-1]} + {{(TB+1){1'b0}}, 1'b1};
   assign idx     = idx_rnd[TB:1];
   assign k_in    = idx[QB] ? ((QB+1)'(tpspwm_pkg::QUARTER_SIZE) - {1'b0, idx[QB-1:0]})
                            : {1'b0, idx[QB-1:0]};

   assign sine_q30   = quarter_rom[k_ff];
   assign num        = neg_ff ? (32'(tpspwm_pkg::ONE_Q30) - {1'b0, sine_q30})
                              : (32'(tpspwm_pkg::ONE_Q30) + {1'b0, sine_q30});
   assign entry_full = {num, {(FB){1'b0}}} + NUM_W'(tpspwm_pkg::ONE_Q30);

   // ceil of the scaled product, then saturate at zero
   assign prod_rnd = {1'b0, prod_ff}
                   + (tpspwm_pkg::PROD_W+1)'((64'd1 << tpspwm_pkg::SCALE_SH) - 64'd1);
   assign sub      = prod_rnd[tpspwm_pkg::PROD_W:tpspwm_pkg::SCALE_SH];
   assign compare  = (sub >= tpspwm_pkg::SUB_W'(period_ff)) ? '0
                   : PW'(tpspwm_pkg::SUB_W'(period_ff) - sub - tpspwm_pkg::SUB_W'(1));

   function automatic logic [CW-1:0] advance(input logic [CW-1:0] cnt);
      logic [CW:0] nxt;
      begin
         nxt = {1'b0, cnt} + {{(CW){1'b0}}, 1'b1};
         return (nxt > {1'b0, wrap_limit_ff}) ? '0 : nxt[CW-1:0];
      end
   endfunction

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      count_c_in = count_c_ff;
      if (cmd.load_output) begin
         count_a_in = advance(count_a_ff);
         count_b_in = advance(count_b_ff);
         count_c_in = advance(count_c_ff);
      end
      if (csr_write) begin
         case (csr_index)
            tpspwm_pkg::REG_START_A: count_a_in = csr_wdata[CW-1:0];
            tpspwm_pkg::REG_START_B: count_b_in = csr_wdata[CW-1:0];
            tpspwm_pkg::REG_START_C: count_c_in = csr_wdata[CW-1:0];
            default: begin
               count_a_in = count_a_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= tpspwm_pkg::PERIOD_RST;
         mod_index_ff  <= tpspwm_pkg::MOD_INDEX_RST;
         phase_step_ff <= tpspwm_pkg::PHASE_STEP_RST;
         wrap_limit_ff <= tpspwm_pkg::WRAP_LIMIT_RST;
         count_a_ff    <= tpspwm_pkg::START_A_RST;
         count_b_ff    <= tpspwm_pkg::START_B_RST;
         count_c_ff    <= tpspwm_pkg::START_C_RST;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         count_c_ff <= count_c_in;
         // start values go straight into the counters
         if (csr_write) begin
            case (csr_index)
               tpspwm_pkg::REG_PERIOD:     period_ff     <= csr_wdata[PW-1:0];
               tpspwm_pkg::REG_MOD_INDEX:  mod_index_ff  <= csr_wdata[tpspwm_pkg::MOD_W-1:0];
               tpspwm_pkg::REG_PHASE_STEP: phase_step_ff <= csr_wdata;
               tpspwm_pkg::REG_WRAP_LIMIT: wrap_limit_ff <= csr_wdata[CW-1:0];
               default: begin
                  period_ff <= period_ff;
               end
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.load_angle) begin
         angle_ff <= angle_full[31:0];
         mp_ff    <= mp_in;
      end
      if (cmd.load_index) begin
         k_ff   <= k_in;
         neg_ff <= idx[TB-1];
      end
      if (cmd.load_entry) begin
         entry_ff <= entry_full[NUM_W-1:31];
      end
      if (cmd.load_product) begin
         prod_ff <= {{(tpspwm_pkg::PROD_W-tpspwm_pkg::MP_W){1'b0}}, mp_ff}
                  * {{(tpspwm_pkg::PROD_W-EW){1'b0}}, entry_ff};
      end
      if (cmd.store_compare) begin
         case (cmd.phase)
            tpspwm_pkg::PHASE_A: comp_a_ff <= compare;
            tpspwm_pkg::PHASE_B: comp_b_ff <= compare;
            default:             comp_c_ff <= compare;
         endcase
      end
      if (cmd.load_output) begin
         out_a_ff <= comp_a_ff;
         out_b_ff <= comp_b_ff;
         out_c_ff <= comp_c_ff;
      end
   end

   assign rsp_compare_a = out_a_ff;
   assign rsp_compare_b = out_b_ff;
   assign rsp_compare_c = out_c_ff;

`ifndef SYNTHESIS
   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_output |=> (count_a_ff <= wrap_limit_ff && count_b_ff <= wrap_limit_ff
                           && count_c_ff <= wrap_limit_ff))
      else $error("counter above wrap limit after advance");

   a_compare_below_period: assert property (@(posedge clock) disable iff (reset)
      cmd.load_output |=> (out_a_ff < period_ff || out_a_ff == '0)
                          && (out_c_ff < period_ff || out_c_ff == '0))
      else $error("compare value not below period");
`endif

endmodule

// ===== rtl/three_phase_sine_pwm_compare_top.sv =====
// Top level of the three-phase sinusoidal PWM compare generator.
// Each accepted word with tick high yields one result word carrying the compare values
// of phases A, B and C. The three phases share one angle multiplier, one quarter-wave
// sine table and one scaling multiplier, each phase passing through five sequencer
// steps (angle, table index, lookup, scale, clamp). After the third phase one delivery
// step moves the result into the output register, waiting while an earlier result is
// still held for rsp_ready, and the block then returns to idle to take the next word;
// a word with tick low is taken and dropped. The next tick is accepted once the result
// has moved into the output register, even while that result still waits on rsp_ready.
// Configuration writes are taken only while the block is idle; writing a start
// register also reloads that phase's sample counter.
module three_phase_sine_pwm_compare_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_tick,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_compare_a,
   output logic [15:0] rsp_compare_b,
   output logic [15:0] rsp_compare_c,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   tpspwm_pkg::dp_cmd_type cmd;
   logic                   csr_write;

   assign csr_write = csr_valid && csr_ready;

   tpspwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_tick  (req_tick),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   tpspwm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_compare_a (rsp_compare_a),
      .rsp_compare_b (rsp_compare_b),
      .rsp_compare_c (rsp_compare_c)
   );

endmodule
